/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ohpa_pkg.sv */
// ----------------------------------------------------------------------------
// ohpa_pkg
// types, codes and default sizes shared by the handle pool allocator
// ----------------------------------------------------------------------------
package ohpa_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int ENTRY_BYTES_DEF = 64;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] owner_id;
        logic [15:0] handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle_out;
    } t_rsp;

    // decoded handle: entry index and whether the handle is a whole entry
    typedef struct packed {
        logic [15:0] idx;
        logic        aligned;
    } t_hdec;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC
    } t_state;

endpackage

/* rtl/ohpa_ram.sv */
// ----------------------------------------------------------------------------
// ohpa_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ohpa_ram #(
    parameter int DW = 16,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ohpa_hdec.sv */
// ----------------------------------------------------------------------------
// ohpa_hdec
// handle decoder: quotient and exactness of handle / entry size by a
// registered reciprocal multiply
// ----------------------------------------------------------------------------
module ohpa_hdec #(
    parameter int ENTRY_BYTES = ohpa_pkg::ENTRY_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic [15:0]        i_handle,
    output ohpa_pkg::t_hdec    o_dec
);

    // ceil(2^25 / entry size) is exact for 16-bit handles and sizes up to 511
    localparam int FRAC_W = 25;
    localparam int RECIP  = ((2 ** FRAC_W) + ENTRY_BYTES - 1) / ENTRY_BYTES;
    localparam int PROD_W = 16 + FRAC_W + 1;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= PROD_W'(i_handle) * PROD_W'(RECIP);
        end
    end

    // fraction below the reciprocal means no remainder
    assign o_dec.idx     = r_prod[FRAC_W+15:FRAC_W];
    assign o_dec.aligned = {1'b0, r_prod[FRAC_W-1:0]} < (FRAC_W + 1)'(RECIP);

endmodule

/* rtl/owned_handle_pool_allocator_unit.sv */
// ----------------------------------------------------------------------------
// owned_handle_pool_allocator_unit
// pool of fixed-size table entries handed out by handle, with a lifo free
// stack and an owner check on free
// ----------------------------------------------------------------------------
// One request item gives exactly one response item. An item is accepted in
// the idle state, and the handle decode multiply is registered at that edge;
// the owner-table and free-stack memories are read in the look state, and
// the memories, counters and response register are updated in the exec
// state, which waits there while the previous response is still stalled at
// the output. The block takes no new item until the current one has left
// the exec state. Allocate pops the most recently freed entry, else builds
// a new one while fewer than MAX_ENTRIES exist, else answers pool full; the
// granted handle is index times ENTRY_BYTES, kept to 16 bits. Free answers
// ok only for an aligned handle of a built entry that the requester owns,
// then clears its owner and pushes it. Owner 0 is refused on both commands.
// The memories need no clearing after reset: only built entries and stack
// slots below the stack top are ever used.
module owned_handle_pool_allocator_unit #(
    parameter int MAX_ENTRIES = ohpa_pkg::MAX_ENTRIES_DEF,
    parameter int ENTRY_BYTES = ohpa_pkg::ENTRY_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  ohpa_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_stall,
    output ohpa_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // control state
    ohpa_pkg::t_state   r_state, n_state;
    logic [CNT_W-1:0]   r_free_top, n_free_top;
    logic [CNT_W-1:0]   r_built, n_built;
    logic               r_rsp_valid, n_rsp_valid;

    // payload
    ohpa_pkg::t_req     r_req;
    ohpa_pkg::t_rsp     r_rsp, n_rsp;

    // decoder and memory ports
    ohpa_pkg::t_hdec    w_dec;
    logic               w_dec_load;
    logic               w_rd_en;
    logic               w_own_we;
    logic [IDX_W-1:0]   w_own_waddr;
    logic [15:0]        w_own_wdata;
    logic [15:0]        w_own_rdata;
    logic               w_stk_we;
    logic [IDX_W-1:0]   w_stk_rdata;
    logic [CNT_W-1:0]   w_top_m1;

    // exec decisions
    logic               w_owner_zero;
    logic               w_stack_nonempty;
    logic               w_can_build;
    logic               w_free_ok;
    logic               w_out_free;
    logic [IDX_W-1:0]   w_grant_idx;
    logic [23:0]        w_grant_prod;

    // ------------------------------------------------------------------
    // handle decode, started at acceptance
    // ------------------------------------------------------------------
    ohpa_hdec #(
        .ENTRY_BYTES (ENTRY_BYTES)
    ) u_hdec (
        .i_clk    (i_clk),
        .i_load   (w_dec_load),
        .i_handle (i_req.handle),
        .o_dec    (w_dec)
    );

    // ------------------------------------------------------------------
    // owner table and free stack
    // ------------------------------------------------------------------
    ohpa_ram #(
        .DW (16),
        .AW (IDX_W)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (w_own_waddr),
        .i_wdata (w_own_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_dec.idx[IDX_W-1:0]),
        .o_rdata (w_own_rdata)
    );

    // stack top minus one is the pop slot; garbage when empty, never used then
    assign w_top_m1 = r_free_top - CNT_W'(1);

    ohpa_ram #(
        .DW (IDX_W),
        .AW (IDX_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_free_top[IDX_W-1:0]),
        .i_wdata (w_dec.idx[IDX_W-1:0]),
        .i_re    (w_rd_en),
        .i_raddr (w_top_m1[IDX_W-1:0]),
        .o_rdata (w_stk_rdata)
    );

    // ------------------------------------------------------------------
    // update decisions, valid in the exec state
    // ------------------------------------------------------------------
    assign w_owner_zero     = (r_req.owner_id == 16'd0);
    assign w_stack_nonempty = (r_free_top != '0);
    assign w_can_build      = (r_built < CNT_W'(MAX_ENTRIES));

    // aligned, built, owned by the requester, and room on the stack
    assign w_free_ok = !w_owner_zero && w_dec.aligned
                       && ({1'b0, w_dec.idx} < 17'(r_built))
                       && (w_own_rdata == r_req.owner_id)
                       && (r_free_top < CNT_W'(MAX_ENTRIES));

    // reuse a freed entry first, else the next new one
    assign w_grant_idx  = w_stack_nonempty ? w_stk_rdata : r_built[IDX_W-1:0];
    assign w_grant_prod = 24'(w_grant_idx) * 24'(ENTRY_BYTES);

    // response register empty or being emptied this cycle
    assign w_out_free = !r_rsp_valid || !i_rsp_stall;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_free_top  = r_free_top;
        n_built     = r_built;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_rsp       = r_rsp;
        w_dec_load  = 1'b0;
        w_rd_en     = 1'b0;
        w_own_we    = 1'b0;
        w_own_waddr = w_dec.idx[IDX_W-1:0];
        w_own_wdata = 16'd0;
        w_stk_we    = 1'b0;

        case (r_state)
            ohpa_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    w_dec_load = 1'b1;
                    n_state    = ohpa_pkg::S_LOOK;
                end
            end
            ohpa_pkg::S_LOOK: begin
                w_rd_en = 1'b1;
                n_state = ohpa_pkg::S_EXEC;
            end
            ohpa_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_state          = ohpa_pkg::S_IDLE;
                    n_rsp_valid      = 1'b1;
                    n_rsp.handle_out = 16'd0;
                    if (r_req.cmd == ohpa_pkg::CMD_ALLOC) begin
                        if (w_owner_zero) begin
                            n_rsp.status = ohpa_pkg::ST_BAD;
                        end else if (w_stack_nonempty || w_can_build) begin
                            // stamp the owner on the popped or new entry
                            w_own_we         = 1'b1;
                            w_own_waddr      = w_grant_idx;
                            w_own_wdata      = r_req.owner_id;
                            n_rsp.status     = ohpa_pkg::ST_OK;
                            n_rsp.handle_out = w_grant_prod[15:0];
                            if (w_stack_nonempty) begin
                                n_free_top = w_top_m1;
                            end else begin
                                n_built = r_built + CNT_W'(1);
                            end
                        end else begin
                            n_rsp.status = ohpa_pkg::ST_FULL;
                        end
                    end else begin
                        if (w_free_ok) begin
                            // clear owner and push the index
                            w_own_we     = 1'b1;
                            w_stk_we     = 1'b1;
                            n_free_top   = r_free_top + CNT_W'(1);
                            n_rsp.status = ohpa_pkg::ST_OK;
                        end else begin
                            n_rsp.status = ohpa_pkg::ST_BAD;
                        end
                    end
                end
            end
            default: begin
                n_state = ohpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ohpa_pkg::S_IDLE;
            r_free_top  <= '0;
            r_built     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_top  <= n_free_top;
            r_built     <= n_built;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_dec_load) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    // one item in flight: take a new one only from idle
    assign o_req_stall = (r_state != ohpa_pkg::S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* rtl/ohpa_chk.sv */
// ----------------------------------------------------------------------------
// ohpa_chk
// port-level checks for the handle pool allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohpa_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            o_req_stall,
    input ohpa_pkg::t_req  i_req,
    input logic            o_rsp_valid,
    input logic            i_rsp_stall,
    input ohpa_pkg::t_rsp  o_rsp
);

    // a stalled response holds
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp), "stalled response changed")

    // refused or full responses carry no handle
    `ASSERT_NOW(a_bad_no_handle, i_clk, i_rst_n, o_rsp_valid && (o_rsp.status != ohpa_pkg::ST_OK), o_rsp.handle_out == 16'd0, "handle on failed response")

    // an accepted item blocks the input while it is worked on
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall, "input open right after accept")

    // a new response comes only out of a busy cycle
    `ASSERT_NOW(a_rsp_from_work, i_clk, i_rst_n, $rose(o_rsp_valid), $past(o_req_stall), "response without work")

endmodule

bind owned_handle_pool_allocator_unit ohpa_chk u_ohpa_chk (.*);
